// File: rtl/geo_pkg.sv
// Package for the geohash encoder: coordinate item type, range bounds and the
// base32 character table. No dependencies.
package geo_pkg;

	// Width of the hash length register.
	localparam int LEN_W = 4;

	// Initial bisection bounds in units of 1e-7 degree.
	localparam logic signed [30:0] LAT_LO = -31'sd900000000;
	localparam logic signed [30:0] LAT_HI = 31'sd900000000;
	localparam logic signed [31:0] LON_LO = -32'sd1800000000;
	localparam logic signed [31:0] LON_HI = 32'sd1800000000;

	// Hash length after reset.
	localparam logic [LEN_W-1:0] LEN_RESET = 4'd9;

	// One coordinate pair together with its current bisection bounds.
	typedef struct packed {
		logic [30:0] lat;
		logic [31:0] lon;
		logic [30:0] lat_lo;
		logic [30:0] lat_hi;
		logic [31:0] lon_lo;
		logic [31:0] lon_hi;
	} geo_item_t;

	// Geohash base32 alphabet.
	localparam logic [7:0] ALPHABET [32] = '{
		"0", "1", "2", "3", "4", "5", "6", "7",
		"8", "9", "b", "c", "d", "e", "f", "g",
		"h", "j", "k", "m", "n", "p", "q", "r",
		"s", "t", "u", "v", "w", "x", "y", "z"
	};

	// Map a five-bit symbol to its 7-bit ASCII character.
	function automatic logic [6:0] geo_ascii(input logic [4:0] sym);
		logic [7:0] ch;
		ch = ALPHABET[sym];
		return ch[6:0];
	endfunction

endpackage

// File: rtl/geo_step.sv
// One pipeline stage of the geohash encoder: one longitude bisection step and,
// if the code word has room, one latitude step side by side. Depends on geo_pkg.
module geo_step #(
	parameter int CODE_W = 60,
	parameter int P      = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  geo_pkg::geo_item_t in_data,
	input  logic [CODE_W-1:0] in_code,
	output logic              out_valid,
	output geo_pkg::geo_item_t out_data,
	output logic [CODE_W-1:0] out_code
);
	import geo_pkg::*;

	// Bit positions of this stage's bits, longitude then latitude if present; the first bit sits at the top.
	localparam int LON_POS = CODE_W - 1 - 2 * P;
	localparam bit HAS_LAT = (2 * P + 1) < CODE_W;
	localparam int LAT_POS = HAS_LAT ? (CODE_W - 2 - 2 * P) : 0;

	logic [32:0]       lon_sum;
	logic [31:0]       lon_mid;
	logic [31:0]       lat_sum;
	logic [30:0]       lat_mid;
	logic              lon_bit;
	logic              lat_bit;
	geo_item_t         data_nx;
	logic [CODE_W-1:0] code_nx;
	logic              valid_s1;
	geo_item_t         data_s1;
	logic [CODE_W-1:0] code_s1;

	// Floor midpoints: sign-extended sum, arithmetic shift by one.
	always_comb begin
		lon_sum = {in_data.lon_lo[31], in_data.lon_lo} + {in_data.lon_hi[31], in_data.lon_hi};
		lon_mid = lon_sum[32:1];
		lat_sum = {in_data.lat_lo[30], in_data.lat_lo} + {in_data.lat_hi[30], in_data.lat_hi};
		lat_mid = lat_sum[31:1];
		lon_bit = $signed(in_data.lon) >= $signed(lon_mid);
		lat_bit = $signed(in_data.lat) >= $signed(lat_mid);
	end

	// Narrow the ranges toward the side the coordinate lies on.
	always_comb begin
		data_nx = in_data;
		if (lon_bit) begin
			data_nx.lon_lo = lon_mid;
		end else begin
			data_nx.lon_hi = lon_mid;
		end
		if (lat_bit) begin
			data_nx.lat_lo = lat_mid;
		end else begin
			data_nx.lat_hi = lat_mid;
		end
	end

	// Insert the new bits into the code word.
	generate
		if (HAS_LAT) begin : g_both
			always_comb begin
				code_nx          = in_code;
				code_nx[LON_POS] = lon_bit;
				code_nx[LAT_POS] = lat_bit;
			end
		end else begin : g_lon
			always_comb begin
				code_nx          = in_code;
				code_nx[LON_POS] = lon_bit;
			end
		end
	endgenerate

	// Stage register; it holds whenever the pipeline is stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_s1 <= data_nx;
			code_s1 <= code_nx;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;
	assign out_code  = code_s1;

endmodule

// File: rtl/geohash_encoder_core.sv
// Top level of the geohash encoder: bisection pipeline and character
// serializer. Depends on geo_pkg and geo_step.
//
// Usage: a coordinate pair enters as one beat on the s_ channel; its geohash
// leaves on the m_ channel as one character per beat, tlast on the final one.
// The cfg channel writes the hash length (0 reads as 1, values above
// MAX_LENGTH read as MAX_LENGTH); write it only while no pair is in flight.
// Structure: a pipeline of ceil(5*MAX_LENGTH/2) stages, each one longitude and,
// where the code word has room, one latitude step, then the output register.
// The serializer sends one character per cycle while the receiver is ready, a
// hash of the clamped length, from 1 up to MAX_LENGTH characters; a new pair enters
// every cycle while the serializer keeps up. When the receiver stalls, the
// output holds and the pipeline stops as a whole once its last stage is full;
// nothing is lost.
// Reset clears all valid bits and sets the hash length to 9.
module geohash_encoder_core #(
	parameter int MAX_LENGTH = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: latitude [30:0], longitude [62:31], bit 63 zero
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,
	// m_tdata: hash_char [6:0], bit 7 zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [geo_pkg::LEN_W-1:0] cfg_data
);
	import geo_pkg::*;

	localparam int CODE_W = 5 * MAX_LENGTH;
	localparam int NSTAGE = (CODE_W + 1) / 2;
	localparam int IDX_W  = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_LENGTH);

	logic              adv;
	logic              load;
	logic              valid_v [NSTAGE+1];
	geo_item_t         data_v  [NSTAGE+1];
	logic [CODE_W-1:0] code_v  [NSTAGE+1];
	logic [LEN_W-1:0]  hash_length_q;
	logic [LEN_W-1:0]  len_clamp;
	logic [LEN_W-1:0]  last_len;
	logic              out_valid_q;
	logic [CODE_W-1:0] out_code_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  last_idx_q;
	logic              out_last;
	logic [4:0]        sym;

	// Configuration register; always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_length_q <= LEN_RESET;
		end else if (cfg_valid) begin
			hash_length_q <= cfg_data;
		end
	end

	// Clamp the length into 1..MAX_LENGTH.
	always_comb begin
		if (hash_length_q == '0) begin
			len_clamp = LEN_W'(1);
		end else if (hash_length_q > MAX_LEN) begin
			len_clamp = MAX_LEN;
		end else begin
			len_clamp = hash_length_q;
		end
		last_len = len_clamp - LEN_W'(1);
	end

	// Pipeline entry with the full coordinate ranges.
	always_comb begin
		valid_v[0]       = s_tvalid;
		data_v[0].lat    = s_tdata[30:0];
		data_v[0].lon    = s_tdata[62:31];
		data_v[0].lat_lo = LAT_LO;
		data_v[0].lat_hi = LAT_HI;
		data_v[0].lon_lo = LON_LO;
		data_v[0].lon_hi = LON_HI;
		code_v[0]        = '0;
	end

	// Bisection stages.
	generate
		for (genvar p = 0; p < NSTAGE; p++) begin : g_stage
			geo_step #(
				.CODE_W (CODE_W),
				.P      (p)
			) u_step (
				.clk       (clk),
				.arst_n    (arst_n),
				.adv       (adv),
				.in_valid  (valid_v[p]),
				.in_data   (data_v[p]),
				.in_code   (code_v[p]),
				.out_valid (valid_v[p+1]),
				.out_data  (data_v[p+1]),
				.out_code  (code_v[p+1])
			);
		end
	endgenerate

	// The serializer takes a new code word when empty or on its final beat.
	assign out_last = idx_q == last_idx_q;
	assign load     = !out_valid_q || (m_tready && out_last);
	assign adv      = !valid_v[NSTAGE] || load;
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= valid_v[NSTAGE];
			idx_q       <= '0;
		end else if (m_tready) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_code_q <= code_v[NSTAGE];
			last_idx_q <= last_len[IDX_W-1:0];
		end
	end

	// Pick the current five-bit symbol, first character at the top.
	always_comb begin
		sym = '0;
		for (int k = 0; k < MAX_LENGTH; k++) begin
			if (idx_q == IDX_W'(k)) begin
				sym = out_code_q[CODE_W-1-5*k -: 5];
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, geo_ascii(sym)};
	assign m_tlast  = out_last;

endmodule

// File: rtl/geo_chk.sv
// Port-level checker for the geohash encoder, bound to geohash_encoder_core.
// Depends only on the top level's ports.
module geo_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast
);

	// A stalled output beat holds its character and end mark.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Every character shown lies in the ASCII range of the alphabet, '0' to 'z'.
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata >= 8'd48 && m_tdata <= 8'd122)
		else $error("character outside the alphabet range");

	// The characters of one hash leave without gaps.
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a hash");

	// An empty output register never holds off a new pair.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && !m_tvalid |-> s_tready)
		else $error("input held off while the output is empty");

	// Nothing is shown while reset is held.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("output valid during reset");

endmodule

bind geohash_encoder_core geo_chk u_geo_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// File: tb/tb.sv
// Self-checking testbench for geohash_encoder_core: drives coordinate pairs and
// hash length writes, predicts every character beat and checks it as it leaves.
// Depends on geo_pkg and the geohash_encoder_core RTL.
module tb;
	import geo_pkg::*;

	localparam int N_DIRECTED  = 16;
	localparam int N_PHASES    = 8;
	localparam int PHASE_PAIRS = 16;
	localparam int HOLD_PAIRS  = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_WAIT  = 40;

	// Hand-picked pairs: range corners, first and second bisection midpoints and
	// their neighbors, values far outside the ranges, and a few real places.
	localparam logic signed [30:0] DIR_LAT [N_DIRECTED] = '{
		0, LAT_LO, LAT_HI, LAT_LO, LAT_HI, -1, 31'sh40000000, 31'sh3fffffff,
		450000000, 449999999, -450000000, -450000001, 0, -1, 488566000, -338688000
	};
	localparam logic signed [31:0] DIR_LON [N_DIRECTED] = '{
		0, LON_LO, LON_HI, LON_HI, LON_LO, -1, 32'sh80000000, 32'sh7fffffff,
		900000000, 899999999, -900000000, -900000001, -1, 0, 23522000, 1512093000
	};
	// Hash length per random phase; a negative entry picks a random length.
	localparam int PHASE_LEN [N_PHASES] = '{1, 0, 12, 15, 13, 5, -1, 12};

	typedef struct packed {
		logic [6:0] ch;
		logic       last;
	} hash_beat_t;

	// Predicts the character beats of each accepted pair and checks them in order.
	class hash_scoreboard;
		hash_beat_t   pending_q[$];
		logic [LEN_W-1:0] hash_len;
		int           errors;

		function new();
			hash_len = LEN_RESET;
			errors = 0;
		endfunction

		function void set_length(logic [LEN_W-1:0] value);
			hash_len = value;
		endfunction

		// Bisect longitude and latitude alternately, five bits per character.
		function void note_pair(logic [30:0] lat_bits, logic [31:0] lon_bits);
			string      alphabet;
			longint     lat, lon, lat_lo, lat_hi, lon_lo, lon_hi, mid;
			int         n_chars;
			bit         on_lon;
			logic [4:0] sym;
			byte        ch;
			hash_beat_t beat;
			alphabet = "0123456789bcdefghjkmnpqrstuvwxyz";
			lat = longint'($signed(lat_bits));
			lon = longint'($signed(lon_bits));
			lat_lo = longint'(LAT_LO);
			lat_hi = longint'(LAT_HI);
			lon_lo = longint'(LON_LO);
			lon_hi = longint'(LON_HI);
			on_lon = 1'b1;
			n_chars = (hash_len == 0) ? 1 : (hash_len > 12) ? 12 : int'(hash_len);
			for (int k = 0; k < n_chars; k++) begin
				sym = '0;
				for (int b = 0; b < 5; b++) begin
					if (on_lon) begin
						// Arithmetic shift of the sum gives the floor of the average.
						mid = (lon_lo + lon_hi) >>> 1;
						if (lon >= mid) begin
							sym = {sym[3:0], 1'b1};
							lon_lo = mid;
						end else begin
							sym = {sym[3:0], 1'b0};
							lon_hi = mid;
						end
					end else begin
						mid = (lat_lo + lat_hi) >>> 1;
						if (lat >= mid) begin
							sym = {sym[3:0], 1'b1};
							lat_lo = mid;
						end else begin
							sym = {sym[3:0], 1'b0};
							lat_hi = mid;
						end
					end
					on_lon = !on_lon;
				end
				ch = alphabet[int'(sym)];
				beat.ch = ch[6:0];
				beat.last = (k == n_chars - 1);
				pending_q.push_back(beat);
			end
		endfunction

		function void check_beat(logic [7:0] data, logic last);
			hash_beat_t want;
			if (pending_q.size() == 0) begin
				$error("unexpected beat: hash_char=%0h last_char=%0b", data, last);
				errors++;
				return;
			end
			want = pending_q.pop_front();
			if (data !== {1'b0, want.ch}) begin
				$error("hash_char mismatch: expected %0h actual %0h", {1'b0, want.ch}, data);
				errors++;
			end
			if (last !== want.last) begin
				$error("last_char mismatch: expected %0b actual %0b", want.last, last);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [63:0]      s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [LEN_W-1:0] cfg_data;

	hash_scoreboard sb;
	bit             idle_on;
	bit             hold_req;

	geohash_encoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	// 12-unit clock period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Mostly in-range latitudes, some near the range edges, some over all 31 bits.
	function automatic logic [30:0] pick_lat();
		longint edge_val;
		case ($urandom_range(0, 9))
			0: return 31'($urandom);
			1: begin
				edge_val = $urandom_range(0, 1) ? longint'(LAT_HI) : longint'(LAT_LO);
				return 31'(edge_val + longint'($urandom_range(0, 16)) - 8);
			end
			default: return 31'(longint'($urandom_range(0, 32'd1800000000)) - 900000000);
		endcase
	endfunction

	function automatic logic [31:0] pick_lon();
		longint edge_val;
		case ($urandom_range(0, 9))
			0: return 32'($urandom);
			1: begin
				edge_val = $urandom_range(0, 1) ? longint'(LON_HI) : longint'(LON_LO);
				return 32'(edge_val + longint'($urandom_range(0, 16)) - 8);
			end
			default: return 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
		endcase
	endfunction

	// Offer one pair and hold it until the block takes the beat.
	task automatic send_pair(logic [30:0] lat, logic [31:0] lon);
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, lon, lat};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_pair(lat, lon);
	endtask

	// Random idle burst on the input side.
	task automatic sender_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every predicted character has left.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_length(logic [LEN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_length(value);
	endtask

	// Output side: random stall bursts, plus one long hold that backs up the block.
	initial begin
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Check every character beat as it is accepted.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_beat(m_tdata, m_tlast);
	end

	// Main sequence: directed pairs, then random phases at several hash lengths.
	initial begin
		int len_sel;
		sb = new();
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pairs at the reset length, then the first six, the corners among them, at full length.
		for (int i = 0; i < N_DIRECTED; i++) begin
			sender_gap();
			send_pair(DIR_LAT[i], DIR_LON[i]);
		end
		wait_drained();
		write_length(4'd12);
		for (int i = 0; i < 6; i++) begin
			sender_gap();
			send_pair(DIR_LAT[i], DIR_LON[i]);
		end

		for (int p = 0; p < N_PHASES; p++) begin
			wait_drained();
			len_sel = (PHASE_LEN[p] < 0) ? int'($urandom_range(0, 15)) : PHASE_LEN[p];
			write_length(LEN_W'(len_sel));
			// Some phases run with no idling at all, the last one among them.
			idle_on = (p != 3) && (p != N_PHASES - 1);
			// The long hold phase offers more pairs than the pipeline can buffer.
			if (p == 2)
				hold_req = 1'b1;
			for (int i = 0; i < ((p == 2) ? HOLD_PAIRS : PHASE_PAIRS); i++) begin
				if (p == 4 && i == 10)
					wait_drained();
				sender_gap();
				send_pair(pick_lat(), pick_lon());
			end
		end

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Watchdog.
	initial begin
		#(12 * 200000);
		$display("DONE: errors detected");
		$finish;
	end

endmodule
